### rtl/ncc_pkg.sv
// Shared types, constants and the table lookup helper for the nibble chain cipher.
// Used by ncc_core and nibble_chain_cipher_28bit_unit; depends on nothing else.
package ncc_pkg;

    localparam int NIB_W   = 4;
    localparam int WORD_W  = 28;
    localparam int NIBS    = 7;
    localparam int TABLE_W = 64;

    localparam logic [NIB_W-1:0]   TOP_XOR       = 4'h9;
    localparam logic [TABLE_W-1:0] TABLE_IDENTITY = 64'hFEDC_BA98_7654_3210;

    typedef enum logic
    {
        FUNC_ENCRYPT = 1'b0,
        FUNC_DECRYPT = 1'b1
    } ncc_func_t;

    typedef enum logic
    {
        CFG_ENCRYPT_TABLE = 1'b0,
        CFG_DECRYPT_TABLE = 1'b1
    } ncc_cfg_idx_t;

    typedef logic [NIB_W-1:0] nib_t;

    // Entry k of a packed table sits at bits 4k+3 down to 4k.
    function automatic nib_t lut(input logic [TABLE_W-1:0] tbl, input nib_t k);
        return tbl[{k, 2'b00} +: NIB_W];
    endfunction

endpackage

### rtl/ncc_core.sv
// Combinational datapath of the nibble chain cipher: encrypt and decrypt of one word.
// Depends on ncc_pkg for widths, the top nibble constant and the table lookup.
module ncc_core
    import ncc_pkg::*;
(
    input  ncc_func_t                  func,
    input  logic [WORD_W-1:0]          data_word,
    input  logic [1:0]                 rolling_id,
    input  logic [TABLE_W-1:0]         encrypt_table,
    input  logic [TABLE_W-1:0]         decrypt_table,
    output logic [WORD_W-1:0]          result_word
);

    logic [WORD_W-1:0] msg;
    logic [WORD_W-1:0] enc_word;
    logic [WORD_W-1:0] rot_in;
    logic [WORD_W-1:0] dec_word;
    nib_t en [NIBS];
    nib_t e0 [NIBS-1];
    nib_t e1 [NIBS-1];
    nib_t dn [NIBS];
    nib_t d0 [NIBS-1];
    nib_t d1 [NIBS-1];
    nib_t key;

    // Encrypt: each round chains through the freshly substituted lower nibble.
    always_comb
    begin
        msg = data_word | {{(WORD_W-8){1'b0}}, rolling_id, 6'b0};
        for (int i = 0; i < NIBS; i++)
        begin
            en[i] = msg[i*NIB_W +: NIB_W];
        end

        key   = en[0] + 4'd1;
        e0[0] = lut(encrypt_table, key);
        for (int i = 1; i < NIBS-1; i++)
        begin
            key   = (en[i] ^ e0[i-1]) + 4'd1;
            e0[i] = lut(encrypt_table, key);
        end

        e1[0] = lut(encrypt_table, e0[0]);
        for (int i = 1; i < NIBS-1; i++)
        begin
            key   = e0[i] ^ e1[i-1];
            e1[i] = lut(encrypt_table, key);
        end

        enc_word[(NIBS-1)*NIB_W +: NIB_W] = en[NIBS-1] ^ TOP_XOR;
        for (int i = 0; i < NIBS-1; i++)
        begin
            enc_word[i*NIB_W +: NIB_W] = e1[i];
        end
    end

    // Decrypt: the inverse rounds mix in the not yet updated lower nibble,
    // so every nibble of a round is independent.
    always_comb
    begin
        rot_in = {data_word[WORD_W-3:0], data_word[WORD_W-1:WORD_W-2]};
        for (int i = 0; i < NIBS; i++)
        begin
            dn[i] = rot_in[i*NIB_W +: NIB_W];
        end
        dn[NIBS-1] = dn[NIBS-1] ^ TOP_XOR;

        d0[0] = lut(decrypt_table, dn[0]);
        for (int i = 1; i < NIBS-1; i++)
        begin
            d0[i] = lut(decrypt_table, dn[i]) ^ dn[i-1];
        end

        d1[0] = lut(decrypt_table, d0[0]) - 4'd1;
        for (int i = 1; i < NIBS-1; i++)
        begin
            d1[i] = (lut(decrypt_table, d0[i]) - 4'd1) ^ d0[i-1];
        end

        dec_word[(NIBS-1)*NIB_W +: NIB_W] = dn[NIBS-1];
        for (int i = 0; i < NIBS-1; i++)
        begin
            dec_word[i*NIB_W +: NIB_W] = d1[i];
        end
    end

    always_comb
    begin
        unique case (func)
            FUNC_ENCRYPT: result_word = {enc_word[1:0], enc_word[WORD_W-1:2]};
            FUNC_DECRYPT: result_word = dec_word;
            default:      result_word = dec_word;
        endcase
    end

endmodule

### rtl/nibble_chain_cipher_28bit_unit.sv
// An accepted input word passes through the input register, then the result register, to the output.
// Throughput: one word per cycle unless the output stalls; the input register feeds the cipher datapath,
// whose output is captured in the result register, and both advance unless a stall holds them.
// Reset clears both valid flags and loads identity substitution tables.
// Top level of the nibble chain cipher; depends on ncc_pkg and ncc_core.
module nibble_chain_cipher_28bit_unit
    import ncc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [WORD_W-1:0]   data_word,
    input  logic [1:0]          rolling_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [WORD_W-1:0]   result_word,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [TABLE_W-1:0]  cfg_data
);

    logic [TABLE_W-1:0] encrypt_table_reg;
    logic [TABLE_W-1:0] decrypt_table_reg;
    logic               s1_valid_reg;
    ncc_func_t          s1_func_reg;
    logic [WORD_W-1:0]  s1_word_reg;
    logic [1:0]         s1_roll_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  result_reg;
    logic [WORD_W-1:0]  result_next;
    logic               out_load;
    logic               s1_load;

    // The result register takes a new word when it is empty or being drained.
    assign out_load = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || out_load;
    assign in_stall = !s1_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encrypt_table_reg <= TABLE_IDENTITY;
            decrypt_table_reg <= TABLE_IDENTITY;
        end
        else if (cfg_we)
        begin
            unique case (ncc_cfg_idx_t'(cfg_index))
                CFG_ENCRYPT_TABLE: encrypt_table_reg <= cfg_data;
                CFG_DECRYPT_TABLE: decrypt_table_reg <= cfg_data;
                default:           encrypt_table_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_func_reg <= ncc_func_t'(func);
            s1_word_reg <= data_word;
            s1_roll_reg <= rolling_id;
        end
        if (out_load && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    ncc_core u_core
    (
        .func          (s1_func_reg),
        .data_word     (s1_word_reg),
        .rolling_id    (s1_roll_reg),
        .encrypt_table (encrypt_table_reg),
        .decrypt_table (decrypt_table_reg),
        .result_word   (result_next)
    );

    assign out_valid   = out_valid_reg;
    assign result_word = result_reg;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> s1_valid_reg)
        else $error("accepted word did not reach the input register");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while the pipeline had room");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_load |=> s1_valid_reg && $stable(s1_word_reg))
        else $error("held input word was lost or changed");

    a_s1_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word in the input register did not reach an empty result register");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for nibble_chain_cipher_28bit_unit: a queue-fed driver,
// a monitor with an in-bench cipher predictor, and table writes between phases.
// Depends on ncc_pkg and the RTL of the unit.
module tb;
    import ncc_pkg::*;

    typedef struct {
        ncc_func_t         op;
        logic [WORD_W-1:0] word;
        logic [1:0]        roll;
    } cipher_req_t;

    localparam int MAX_REPORTS   = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int LONG_HOLD     = 64;
    localparam int DRAIN_CYCLES  = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                func = 1'b0;
    logic [WORD_W-1:0]   data_word = '0;
    logic [1:0]          rolling_id = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [WORD_W-1:0]   result_word;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [TABLE_W-1:0]  cfg_data = '0;

    // Copies of the substitution tables as last written to the unit.
    logic [TABLE_W-1:0]  enc_tbl = TABLE_IDENTITY;
    logic [TABLE_W-1:0]  dec_tbl = TABLE_IDENTITY;

    cipher_req_t         words_to_send[$];
    logic [WORD_W-1:0]   predicted_results[$];
    cipher_req_t         next_req;
    logic [WORD_W-1:0]   want;
    logic                in_taken = 1'b0;
    int                  send_idle_pct = 26;
    int                  recv_idle_pct = 47;
    logic                send_pause = 1'b0;
    int                  hold_requests = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;
    int                  error_count = 0;
    int                  results_seen = 0;
    int                  quiet_cycles = 0;

    nibble_chain_cipher_28bit_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .data_word   (data_word),
        .rolling_id  (rolling_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_word (result_word),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic nib_t sbox(input logic [TABLE_W-1:0] tbl, input nib_t k);
        return tbl[4*k +: NIB_W];
    endfunction

    function automatic logic [WORD_W-1:0] encrypt_word(input logic [WORD_W-1:0] plain,
                                                       input logic [1:0] roll);
        nib_t              n [NIBS];
        logic [WORD_W-1:0] w;
        w = plain;
        w[7:6] = w[7:6] | roll;
        for (int i = 0; i < NIBS; i++)
            n[i] = w[4*i +: NIB_W];
        // Each nibble is chained to its predecessor after that one was substituted.
        for (int r = 0; r < 2; r++)
        begin
            n[0] = sbox(enc_tbl, nib_t'(n[0] + 1 - r));
            for (int i = 1; i <= 5; i++)
                n[i] = sbox(enc_tbl, nib_t'((n[i] ^ n[i-1]) + 1 - r));
        end
        n[6] = n[6] ^ TOP_XOR;
        for (int i = 0; i < NIBS; i++)
            w[4*i +: NIB_W] = n[i];
        return {w[1:0], w[WORD_W-1:2]};
    endfunction

    function automatic logic [WORD_W-1:0] decrypt_word(input logic [WORD_W-1:0] code);
        nib_t              n [NIBS];
        logic [WORD_W-1:0] w;
        w = {code[WORD_W-3:0], code[WORD_W-1:WORD_W-2]};
        for (int i = 0; i < NIBS; i++)
            n[i] = w[4*i +: NIB_W];
        n[6] = n[6] ^ TOP_XOR;
        // Walking downward, each nibble still sees its predecessor's coded value.
        for (int r = 0; r < 2; r++)
        begin
            for (int i = 5; i >= 1; i--)
                n[i] = nib_t'(sbox(dec_tbl, n[i]) - r) ^ n[i-1];
            n[0] = nib_t'(sbox(dec_tbl, n[0]) - r);
        end
        for (int i = 0; i < NIBS; i++)
            w[4*i +: NIB_W] = n[i];
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] cipher_word(input cipher_req_t req);
        if (req.op == FUNC_ENCRYPT)
            return encrypt_word(req.word, req.roll);
        else
            return decrypt_word(req.word);
    endfunction

    task automatic flag_error(input string what, input logic [WORD_W-1:0] exp_w,
                              input logic [WORD_W-1:0] got_w);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR %s at result %0d: expected %07h, got %07h",
                     what, results_seen, exp_w, got_w);
    endtask

    // Driver: a new word is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (words_to_send.size() != 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct)
            begin
                next_req = words_to_send.pop_front();
                in_valid <= 1'b1;
                func <= next_req.op;
                data_word <= next_req.word;
                rolling_id <= next_req.roll;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with an occasional long hold on request.
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor: checks result words, predicts for accepted input words, and
    // ends the run if traffic stops.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                begin
                    flag_error("unexpected result word", '0, result_word);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (result_word !== want)
                        flag_error("result word mismatch", want, result_word);
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
                predicted_results.push_back(cipher_word('{ncc_func_t'(func), data_word,
                                                          rolling_id}));
            in_taken <= in_valid && !in_stall;

            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic push_word(input ncc_func_t op, input logic [WORD_W-1:0] word,
                             input logic [1:0] roll);
        words_to_send.push_back('{op, word, roll});
    endtask

    task automatic write_table(input ncc_cfg_idx_t idx, input logic [TABLE_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == CFG_ENCRYPT_TABLE)
            enc_tbl = value;
        else
            dec_tbl = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_permutation();
        nib_t               perm [16];
        logic [TABLE_W-1:0] fwd;
        logic [TABLE_W-1:0] inv;
        int                 j;
        nib_t               t;
        for (int k = 0; k < 16; k++)
            perm[k] = nib_t'(k);
        for (int k = 15; k > 0; k--)
        begin
            j = $urandom_range(k);
            t = perm[k];
            perm[k] = perm[j];
            perm[j] = t;
        end
        for (int k = 0; k < 16; k++)
        begin
            fwd[4*k +: NIB_W] = perm[k];
            inv[4*perm[k] +: NIB_W] = nib_t'(k);
        end
        write_table(CFG_ENCRYPT_TABLE, fwd);
        write_table(CFG_DECRYPT_TABLE, inv);
    endtask

    // Mostly encrypt/decrypt round trips; the rest are lone words of either kind.
    task automatic add_random_words(input int count);
        logic [WORD_W-1:0] w;
        logic [1:0]        roll;
        int                pick;
        int                added;
        added = 0;
        while (added < count)
        begin
            w = WORD_W'($urandom());
            roll = 2'($urandom());
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                push_word(FUNC_ENCRYPT, w, roll);
                push_word(FUNC_DECRYPT, encrypt_word(w, roll), 2'($urandom()));
                added += 2;
            end
            else
            begin
                push_word(pick < 70 ? FUNC_ENCRYPT : FUNC_DECRYPT, w, roll);
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        while (words_to_send.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Directed words under the identity tables.
        push_word(FUNC_ENCRYPT, 28'h0000000, 2'd0);
        push_word(FUNC_ENCRYPT, 28'h0000000, 2'd3);
        push_word(FUNC_ENCRYPT, 28'hFFFFFFF, 2'd0);
        push_word(FUNC_ENCRYPT, 28'hFFFFFFF, 2'd3);
        // Plain bits 7:6 already set are merged with the rolling code.
        push_word(FUNC_ENCRYPT, 28'h00000C0, 2'd1);
        push_word(FUNC_ENCRYPT, 28'h0000040, 2'd2);
        push_word(FUNC_ENCRYPT, 28'hAAAAAAA, 2'd1);
        push_word(FUNC_ENCRYPT, 28'h5555555, 2'd2);
        push_word(FUNC_ENCRYPT, 28'h0000001, 2'd0);
        push_word(FUNC_ENCRYPT, 28'h8000000, 2'd0);
        push_word(FUNC_DECRYPT, 28'h0000000, 2'd0);
        // The rolling code must not affect a decrypt.
        push_word(FUNC_DECRYPT, 28'h0000000, 2'd3);
        push_word(FUNC_DECRYPT, 28'hFFFFFFF, 2'd0);
        push_word(FUNC_DECRYPT, 28'hFFFFFFF, 2'd2);
        push_word(FUNC_DECRYPT, 28'hAAAAAAA, 2'd1);
        push_word(FUNC_DECRYPT, 28'h5555555, 2'd0);
        push_word(FUNC_DECRYPT, 28'h0000003, 2'd0);
        push_word(FUNC_DECRYPT, 28'hC000000, 2'd0);
        push_word(FUNC_ENCRYPT, 28'h1234567, 2'd2);
        push_word(FUNC_DECRYPT, encrypt_word(28'h1234567, 2'd2), 2'd1);
        wait_drained();

        load_permutation();
        add_random_words(600);
        wait_drained();

        send_idle_pct = 47;
        recv_idle_pct = 26;
        // Tables that are not permutations: all zero, all ones, then arbitrary.
        write_table(CFG_ENCRYPT_TABLE, '0);
        write_table(CFG_DECRYPT_TABLE, '0);
        add_random_words(30);
        wait_drained();
        write_table(CFG_ENCRYPT_TABLE, '1);
        write_table(CFG_DECRYPT_TABLE, '1);
        add_random_words(30);
        wait_drained();
        write_table(CFG_ENCRYPT_TABLE, {$urandom(), $urandom()});
        write_table(CFG_DECRYPT_TABLE, {$urandom(), $urandom()});
        add_random_words(500);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_permutation();
        add_random_words(400);
        // The receiver holds off while words keep coming, so the unit backs up.
        hold_requests++;
        while (words_to_send.size() > 250)
            @(posedge clk);
        send_pause = 1'b1;
        while (in_valid || predicted_results.size() != 0)
            @(posedge clk);
        send_pause = 1'b0;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (predicted_results.size() != 0)
            flag_error("missing result word", predicted_results[0], '0);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
rtl/ncc_pkg.sv
rtl/ncc_core.sv
rtl/nibble_chain_cipher_28bit_unit.sv
bench/tb.sv
